// ===== design/tshc_pkg.sv =====
// Shared types and codes for the two-site effective Hamiltonian block.
`timescale 1ns / 1ps

package tshc_pkg;

    // Item function codes
    typedef enum logic [2:0] {
        FN_LOAD_L     = 3'd0,
        FN_LOAD_R     = 3'd1,
        FN_LOAD_W1    = 3'd2,
        FN_LOAD_W2    = 3'd3,
        FN_LOAD_THETA = 3'd4,
        FN_COMPUTE    = 3'd5,
        FN_READ       = 3'd6,
        FN_NONE       = 3'd7
    } t_func;

    // Configuration register indexes
    localparam logic [2:0] CFG_LEFT_BOND  = 3'd0;
    localparam logic [2:0] CFG_RIGHT_BOND = 3'd1;
    localparam logic [2:0] CFG_PHYS       = 3'd2;
    localparam logic [2:0] CFG_MPO        = 3'd3;

    // Contraction stage
    typedef enum logic [1:0] {
        STG_T1  = 2'd0,
        STG_T2  = 2'd1,
        STG_T3  = 2'd2,
        STG_RES = 2'd3
    } t_stage;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // item taken this cycle
        logic start_comp;  // reset counters, stage and flag
        logic addr_en;     // register operand addresses
        logic mul_en;      // register product
        logic acc_en;      // accumulate product, step inner counters
        logic wr_en;       // saturate, store, step outer counters
        logic emit_done;   // compute finished result
        logic emit_read;   // read data result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic inner_last;
        logic outer_last;
        logic stage_last;
    } t_stat;

endpackage

// ===== design/tshc_ctrl.sv =====
// Sequencer for loads, reads and the four-stage contraction.
`timescale 1ns / 1ps

module tshc_ctrl
    import tshc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_func,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PREP  = 9'b000000010,
        ST_ADDR  = 9'b000000100,
        ST_READ  = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_ACC   = 9'b000100000,
        ST_WRITE = 9'b001000000,
        ST_DONE  = 9'b010000000,
        ST_RDOUT = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_prep, n_prep;
    logic       accept;

    assign accept = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        n_prep  = r_prep;
        unique case (r_state)
            ST_IDLE: begin
                n_prep = 2'd0;
                if (accept) begin
                    if (t_func'(i_func) == FN_COMPUTE) begin
                        n_state = ST_PREP;
                    end else if (t_func'(i_func) == FN_READ) begin
                        n_state = ST_RDOUT;
                    end
                end
            end
            ST_PREP: begin
                // wait here while the stride chain settles
                n_prep = r_prep + 2'd1;
                if (r_prep == 2'd3) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR:  n_state = ST_READ;
            ST_READ:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   n_state = i_stat.inner_last ? ST_WRITE : ST_ADDR;
            ST_WRITE: begin
                n_state = (i_stat.outer_last && i_stat.stage_last) ? ST_DONE : ST_ADDR;
            end
            ST_DONE:  n_state = ST_IDLE;
            ST_RDOUT: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_prep  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_prep  <= n_prep;
        end
    end

    // Commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = accept;
        o_cmd.start_comp = accept && (t_func'(i_func) == FN_COMPUTE);
        o_cmd.addr_en    = (r_state == ST_ADDR);
        o_cmd.mul_en     = (r_state == ST_MUL);
        o_cmd.acc_en     = (r_state == ST_ACC);
        o_cmd.wr_en      = (r_state == ST_WRITE);
        o_cmd.emit_done  = (r_state == ST_DONE);
        o_cmd.emit_read  = (r_state == ST_RDOUT);
    end

endmodule

// ===== design/tshc_datapath.sv =====
// Stores, loop counters, address generation and the Q16.16 MAC.
`timescale 1ns / 1ps

module tshc_datapath
    import tshc_pkg::*;
#(
    parameter int BOND_LIMIT = 16,
    parameter int MAX_PHYS   = 2,
    parameter int MAX_MPO    = 4,
    parameter int BW         = 5,
    parameter int PW         = 2,
    parameter int MW         = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [2:0]         i_func,
    input  logic [9:0]         i_elem_index,
    input  logic signed [31:0] i_elem_value,
    input  logic [BW-1:0]      i_cl,
    input  logic [BW-1:0]      i_cr,
    input  logic [PW-1:0]      i_d,
    input  logic [MW-1:0]      i_dm,
    output logic               o_result_valid,
    output logic               o_result_kind,
    output logic signed [31:0] o_read_value,
    output logic               o_saturated
);

    localparam int ENV_DEPTH = BOND_LIMIT * MAX_MPO * BOND_LIMIT;
    localparam int OP_DEPTH  = MAX_MPO * MAX_PHYS * MAX_PHYS * MAX_MPO;
    localparam int PSI_DEPTH = BOND_LIMIT * MAX_PHYS * MAX_PHYS * BOND_LIMIT;
    localparam int SCR_DEPTH = MAX_MPO * PSI_DEPTH;
    localparam int EAW = (ENV_DEPTH > 1) ? $clog2(ENV_DEPTH) : 1;
    localparam int OAW = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
    localparam int PAW = (PSI_DEPTH > 1) ? $clog2(PSI_DEPTH) : 1;
    localparam int SAW = (SCR_DEPTH > 1) ? $clog2(SCR_DEPTH) : 1;
    localparam int SW  = $clog2(SCR_DEPTH + 1);
    localparam int MAXD_A = (BOND_LIMIT > MAX_MPO) ? BOND_LIMIT : MAX_MPO;
    localparam int MAXD   = (MAXD_A > MAX_PHYS) ? MAXD_A : MAX_PHYS;
    localparam int CW     = $clog2(MAXD + 1);

    // Memories
    logic signed [31:0] l_mem   [0:ENV_DEPTH-1];
    logic signed [31:0] r_mem   [0:ENV_DEPTH-1];
    logic signed [31:0] w1_mem  [0:OP_DEPTH-1];
    logic signed [31:0] w2_mem  [0:OP_DEPTH-1];
    logic signed [31:0] th_mem  [0:PSI_DEPTH-1];
    logic signed [31:0] s1_mem  [0:SCR_DEPTH-1];
    logic signed [31:0] s2_mem  [0:SCR_DEPTH-1];
    logic signed [31:0] res_mem [0:PSI_DEPTH-1];

    logic signed [31:0] r_l_q, r_r_q, r_w1_q, r_w2_q, r_th_q, r_s1_q, r_s2_q, r_res_q;

    t_stage          r_stage;
    logic [CW-1:0]   r_x [0:4];
    logic [CW-1:0]   r_y [0:1];
    logic [CW-1:0]   xl  [0:4];
    logic [CW-1:0]   yl  [0:1];
    logic [CW-1:0]   cl, cr, dd, dm;

    logic [SW-1:0]   r_cd, r_cdd, r_cddm, r_cm, r_dmd, r_dmdd, r_cmd, r_cmdd, r_rm;
    logic [SW-1:0]   n_addr_a, n_addr_b, n_addr_w;
    logic [SW-1:0]   r_addr_a, r_addr_b, r_addr_w;

    logic signed [63:0] r_prod, r_acc;
    logic signed [31:0] op_a, op_b, sat_val;
    logic               sat_hit;
    logic               r_sat;
    logic               r_rd_ok;
    logic               inner_last, outer_last;

    function automatic logic [SW-1:0] term(input logic [CW-1:0] x, input logic [SW-1:0] s);
        logic [SW+CW-1:0] p;
        p = x * s;
        return p[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] ext(input logic [CW-1:0] x);
        return SW'(x);
    endfunction

    assign cl = CW'(i_cl);
    assign cr = CW'(i_cr);
    assign dd = CW'(i_d);
    assign dm = CW'(i_dm);

    // Strides, a three-deep chain of narrow products
    always_ff @(posedge i_clk) begin
        r_cd   <= term(dd, ext(cl));
        r_cm   <= term(dm, ext(cl));
        r_dmd  <= term(dd, ext(dm));
        r_rm   <= term(dm, ext(cr));
        r_cdd  <= term(dd, r_cd);
        r_cmd  <= term(dd, r_cm);
        r_dmdd <= term(dd, r_dmd);
        r_cddm <= term(dm, r_cdd);
        r_cmdd <= term(dd, r_cmd);
    end

    // Loop limits for the current stage
    always_comb begin
        case (r_stage)
            STG_T1: begin
                xl[0] = dm; xl[1] = cl; xl[2] = dd; xl[3] = dd; xl[4] = cr;
                yl[0] = cl; yl[1] = CW'(1);
            end
            STG_T2: begin
                xl[0] = dm; xl[1] = cl; xl[2] = dd; xl[3] = dd; xl[4] = cr;
                yl[0] = dm; yl[1] = dd;
            end
            STG_T3: begin
                xl[0] = cl; xl[1] = dd; xl[2] = dd; xl[3] = dm; xl[4] = cr;
                yl[0] = dm; yl[1] = dd;
            end
            default: begin
                xl[0] = cl; xl[1] = dd; xl[2] = dd; xl[3] = cr; xl[4] = CW'(1);
                yl[0] = dm; yl[1] = cr;
            end
        endcase
    end

    assign inner_last = (r_y[0] == yl[0] - CW'(1)) && (r_y[1] == yl[1] - CW'(1));
    assign outer_last = (r_x[0] == xl[0] - CW'(1)) && (r_x[1] == xl[1] - CW'(1)) &&
                        (r_x[2] == xl[2] - CW'(1)) && (r_x[3] == xl[3] - CW'(1)) &&
                        (r_x[4] == xl[4] - CW'(1));

    assign o_stat.inner_last = inner_last;
    assign o_stat.outer_last = outer_last;
    assign o_stat.stage_last = (r_stage == STG_RES);

    // Loop counters and stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= STG_T1;
            for (int i = 0; i < 5; i++) r_x[i] <= '0;
            for (int i = 0; i < 2; i++) r_y[i] <= '0;
        end else if (i_cmd.start_comp) begin
            r_stage <= STG_T1;
            for (int i = 0; i < 5; i++) r_x[i] <= '0;
            for (int i = 0; i < 2; i++) r_y[i] <= '0;
        end else begin
            if (i_cmd.acc_en) begin
                if (r_y[0] == yl[0] - CW'(1)) begin
                    r_y[0] <= '0;
                    r_y[1] <= (r_y[1] == yl[1] - CW'(1)) ? '0 : r_y[1] + CW'(1);
                end else begin
                    r_y[0] <= r_y[0] + CW'(1);
                end
            end
            if (i_cmd.wr_en) begin
                if (outer_last) begin
                    for (int i = 0; i < 5; i++) r_x[i] <= '0;
                    case (r_stage)
                        STG_T1:  r_stage <= STG_T2;
                        STG_T2:  r_stage <= STG_T3;
                        STG_T3:  r_stage <= STG_RES;
                        default: r_stage <= STG_T1;
                    endcase
                end else if (r_x[0] != xl[0] - CW'(1)) begin
                    r_x[0] <= r_x[0] + CW'(1);
                end else if (r_x[1] != xl[1] - CW'(1)) begin
                    r_x[0] <= '0;
                    r_x[1] <= r_x[1] + CW'(1);
                end else if (r_x[2] != xl[2] - CW'(1)) begin
                    r_x[0] <= '0; r_x[1] <= '0;
                    r_x[2] <= r_x[2] + CW'(1);
                end else if (r_x[3] != xl[3] - CW'(1)) begin
                    r_x[0] <= '0; r_x[1] <= '0; r_x[2] <= '0;
                    r_x[3] <= r_x[3] + CW'(1);
                end else begin
                    r_x[0] <= '0; r_x[1] <= '0; r_x[2] <= '0; r_x[3] <= '0;
                    r_x[4] <= r_x[4] + CW'(1);
                end
            end
        end
    end

    // Operand and destination addresses, column-major
    always_comb begin
        case (r_stage)
            STG_T1: begin
                n_addr_a = ext(r_y[0]) + term(r_x[0], ext(cl)) + term(r_x[1], r_cm);
                n_addr_b = ext(r_y[0]) + term(r_x[2], ext(cl)) + term(r_x[3], r_cd)
                         + term(r_x[4], r_cdd);
                n_addr_w = ext(r_x[0]) + term(r_x[1], ext(dm)) + term(r_x[2], r_cm)
                         + term(r_x[3], r_cmd) + term(r_x[4], r_cmdd);
            end
            STG_T2: begin
                n_addr_a = ext(r_y[0]) + term(r_y[1], ext(dm)) + term(r_x[2], r_dmd)
                         + term(r_x[0], r_dmdd);
                n_addr_b = ext(r_y[0]) + term(r_x[1], ext(dm)) + term(r_y[1], r_cm)
                         + term(r_x[3], r_cmd) + term(r_x[4], r_cmdd);
                n_addr_w = ext(r_x[0]) + term(r_x[1], ext(dm)) + term(r_x[2], r_cm)
                         + term(r_x[3], r_cmd) + term(r_x[4], r_cmdd);
            end
            STG_T3: begin
                n_addr_a = ext(r_y[0]) + term(r_y[1], ext(dm)) + term(r_x[2], r_dmd)
                         + term(r_x[3], r_dmdd);
                n_addr_b = ext(r_y[0]) + term(r_x[0], ext(dm)) + term(r_x[1], r_cm)
                         + term(r_y[1], r_cmd) + term(r_x[4], r_cmdd);
                n_addr_w = ext(r_x[0]) + term(r_x[1], ext(cl)) + term(r_x[2], r_cd)
                         + term(r_x[3], r_cdd) + term(r_x[4], r_cddm);
            end
            default: begin
                n_addr_a = ext(r_y[1]) + term(r_y[0], ext(cr)) + term(r_x[3], r_rm);
                n_addr_b = ext(r_x[0]) + term(r_x[1], ext(cl)) + term(r_x[2], r_cd)
                         + term(r_y[0], r_cdd) + term(r_y[1], r_cddm);
                n_addr_w = ext(r_x[0]) + term(r_x[1], ext(cl)) + term(r_x[2], r_cd)
                         + term(r_x[3], r_cdd);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr_en) begin
            r_addr_a <= n_addr_a;
            r_addr_b <= n_addr_b;
            r_addr_w <= n_addr_w;
        end
    end

    // Saturation of the finished sum
    always_comb begin
        sat_hit = 1'b0;
        sat_val = r_acc[31:0];
        if (r_acc > 64'sd2147483647) begin
            sat_hit = 1'b1;
            sat_val = 32'sh7fffffff;
        end else if (r_acc < -64'sd2147483648) begin
            sat_hit = 1'b1;
            sat_val = 32'sh80000000;
        end
    end

    // Memory writes: element loads and stage results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            case (t_func'(i_func))
                FN_LOAD_L: begin
                    if (32'(i_elem_index) < ENV_DEPTH) l_mem[EAW'(i_elem_index)] <= i_elem_value;
                end
                FN_LOAD_R: begin
                    if (32'(i_elem_index) < ENV_DEPTH) r_mem[EAW'(i_elem_index)] <= i_elem_value;
                end
                FN_LOAD_W1: begin
                    if (32'(i_elem_index) < OP_DEPTH) w1_mem[OAW'(i_elem_index)] <= i_elem_value;
                end
                FN_LOAD_W2: begin
                    if (32'(i_elem_index) < OP_DEPTH) w2_mem[OAW'(i_elem_index)] <= i_elem_value;
                end
                FN_LOAD_THETA: begin
                    if (32'(i_elem_index) < PSI_DEPTH) th_mem[PAW'(i_elem_index)] <= i_elem_value;
                end
                default: ;
            endcase
        end
        if (i_cmd.wr_en) begin
            case (r_stage)
                STG_T1:  s1_mem[SAW'(r_addr_w)]  <= sat_val;
                STG_T2:  s2_mem[SAW'(r_addr_w)]  <= sat_val;
                STG_T3:  s1_mem[SAW'(r_addr_w)]  <= sat_val;
                default: res_mem[PAW'(r_addr_w)] <= sat_val;
            endcase
        end
    end

    // Registered memory reads
    always_ff @(posedge i_clk) begin
        r_l_q   <= l_mem[EAW'(r_addr_a)];
        r_r_q   <= r_mem[EAW'(r_addr_a)];
        r_w1_q  <= w1_mem[OAW'(r_addr_a)];
        r_w2_q  <= w2_mem[OAW'(r_addr_a)];
        r_th_q  <= th_mem[PAW'(r_addr_b)];
        r_s1_q  <= s1_mem[SAW'(r_addr_b)];
        r_s2_q  <= s2_mem[SAW'(r_addr_b)];
        r_res_q <= res_mem[PAW'(i_elem_index)];
    end

    // Operand select
    always_comb begin
        case (r_stage)
            STG_T1:  begin op_a = r_l_q;  op_b = r_th_q; end
            STG_T2:  begin op_a = r_w1_q; op_b = r_s1_q; end
            STG_T3:  begin op_a = r_w2_q; op_b = r_s2_q; end
            default: begin op_a = r_r_q;  op_b = r_s1_q; end
        endcase
    end

    // Multiply, floor shift to Q16.16, accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= op_a * op_b;
        if (i_cmd.start_comp || i_cmd.wr_en) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + (r_prod >>> 16);
        end
    end

    // Saturation flag and read range check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat   <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.start_comp) begin
                r_sat <= 1'b0;
            end else if (i_cmd.wr_en && sat_hit) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.accept) r_rd_ok <= (32'(i_elem_index) < PSI_DEPTH);
        end
    end

    // Result ports
    assign o_result_valid = i_cmd.emit_done || i_cmd.emit_read;
    assign o_result_kind  = i_cmd.emit_read;
    assign o_read_value   = (i_cmd.emit_read && r_rd_ok) ? r_res_q : 32'sd0;
    assign o_saturated    = r_sat;

endmodule

// ===== design/two_site_heff_contraction.sv =====
// Top level: configuration registers, sequencer and contraction datapath.
//
// Usage. An item is taken at a rising edge with i_start high and o_busy
// low; i_func selects a load (left env, right env, W1, W2, theta), a
// compute or a read. Loads write one element at i_elem_index. A read returns
// one result element on the next cycle. A compute runs the four contractions
// on one shared multiply-accumulate unit and reports completion with result
// kind 0.
// Results appear on o_result_* for exactly one cycle with o_result_valid
// high; the receiver cannot stall, so the block never waits on it.
// Loads leave o_busy low; a read or a compute holds o_busy high until its
// result is shown, so no new item is taken meanwhile. A compute forms its
// products one at a time on the single multiplier.
// Configuration is written on i_cfg_valid (o_cfg_ready is always high);
// the user must write it only while the block is idle; this is not enforced.
// Values of 0 read as 1; values above the maximum clamp to it. Reset sets
// dimensions to maxima and clears the saturation flag; stores are not reset.
`timescale 1ns / 1ps

module two_site_heff_contraction
    import tshc_pkg::*;
#(
    parameter int BOND_LIMIT = 16,
    parameter int MAX_PHYS   = 2,
    parameter int MAX_MPO    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_func,
    input  logic [9:0]         i_elem_index,
    input  logic signed [31:0] i_elem_value,
    output logic               o_result_valid,
    output logic               o_result_kind,
    output logic signed [31:0] o_read_value,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    localparam int BW = $clog2(BOND_LIMIT + 1);
    localparam int PW = $clog2(MAX_PHYS + 1);
    localparam int MW = $clog2(MAX_MPO + 1);
    localparam int RST_BOND = (16 > BOND_LIMIT) ? BOND_LIMIT : 16;
    localparam int RST_PHYS = (2 > MAX_PHYS) ? MAX_PHYS : 2;
    localparam int RST_MPO  = (4 > MAX_MPO) ? MAX_MPO : 4;

    logic [BW-1:0] r_cl, r_cr;
    logic [PW-1:0] r_d;
    logic [MW-1:0] r_dm;
    t_cmd          cmd;
    t_stat         stat;

    assign o_cfg_ready = 1'b1;

    function automatic int clamp(input int v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Dimension registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl <= BW'(RST_BOND);
            r_cr <= BW'(RST_BOND);
            r_d  <= PW'(RST_PHYS);
            r_dm <= MW'(RST_MPO);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEFT_BOND:  r_cl <= BW'(clamp(int'(i_cfg_data[4:0]), BOND_LIMIT));
                CFG_RIGHT_BOND: r_cr <= BW'(clamp(int'(i_cfg_data[4:0]), BOND_LIMIT));
                CFG_PHYS:       r_d  <= PW'(clamp(int'(i_cfg_data[1:0]), MAX_PHYS));
                CFG_MPO:        r_dm <= MW'(clamp(int'(i_cfg_data[2:0]), MAX_MPO));
                default: ;
            endcase
        end
    end

    tshc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    tshc_datapath #(
        .BOND_LIMIT (BOND_LIMIT),
        .MAX_PHYS   (MAX_PHYS),
        .MAX_MPO    (MAX_MPO),
        .BW         (BW),
        .PW         (PW),
        .MW         (MW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_func         (i_func),
        .i_elem_index   (i_elem_index),
        .i_elem_value   (i_elem_value),
        .i_cl           (r_cl),
        .i_cr           (r_cr),
        .i_d            (r_d),
        .i_dm           (r_dm),
        .o_result_valid (o_result_valid),
        .o_result_kind  (o_result_kind),
        .o_read_value   (o_read_value),
        .o_saturated    (o_saturated)
    );

endmodule

// ===== bench/two_site_heff_contraction_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the two-site Hamiltonian contraction: a built-in predictor checks every result.

module two_site_heff_contraction_tb;
    import tshc_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ENV_SIZE    = 1024;
    localparam int OP_SIZE     = 64;
    localparam int THETA_SIZE  = 1024;
    localparam int SCR_SIZE    = 4096;
    localparam int PHASE_ITEMS = 16;

    typedef struct {
        logic               kind;
        logic signed [31:0] value;
        logic               sat;
    } t_heff_result;

    // Expected results in issue order, checked against the strobed outputs
    class heff_scoreboard;
        t_heff_result pending[$];
        int           mismatches;

        function void note_expected(t_heff_result r);
            pending.push_back(r);
        endfunction

        function void check_result(logic kind, logic signed [31:0] value, logic sat);
            t_heff_result e;
            if (pending.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: kind %0d value %0d sat %0d", kind, value, sat);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            if (e.kind !== kind || e.value !== value || e.sat !== sat) begin
                if (mismatches < 10)
                    $display("mismatch: exp kind %0d value %0d sat %0d, got %0d %0d %0d",
                             e.kind, e.value, e.sat, kind, value, sat);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic [2:0]         i_func = FN_NONE;
    logic [9:0]         i_elem_index = '0;
    logic signed [31:0] i_elem_value = '0;
    logic               i_cfg_valid = 1'b0;
    logic [2:0]         i_cfg_index = CFG_LEFT_BOND;
    logic [7:0]         i_cfg_data = '0;
    logic               o_busy, o_result_valid, o_result_kind, o_saturated, o_cfg_ready;
    logic signed [31:0] o_read_value;

    heff_scoreboard sb = new;
    int cycles = 0;
    int idle_pct = 0;
    int items_done = 0;

    // Predictor state
    int dim_l = 16, dim_r = 16, dim_p = 2, dim_m = 4;
    int env_left[ENV_SIZE], env_right[ENV_SIZE], op_left[OP_SIZE], op_right[OP_SIZE];
    int theta[THETA_SIZE], scr_a[SCR_SIZE], scr_b[SCR_SIZE], heff_out[THETA_SIZE];
    bit has_left[ENV_SIZE], has_right[ENV_SIZE], has_w1[OP_SIZE], has_w2[OP_SIZE];
    bit has_theta[THETA_SIZE], has_out[THETA_SIZE];
    bit sat_now = 1'b0;

    two_site_heff_contraction dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_func        (i_func),
        .i_elem_index  (i_elem_index),
        .i_elem_value  (i_elem_value),
        .o_result_valid(o_result_valid),
        .o_result_kind (o_result_kind),
        .o_read_value  (o_read_value),
        .o_saturated   (o_saturated),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_result_kind, o_read_value, o_saturated);
    end

    // Q16.16 product, floor-shifted
    function automatic longint mul_q16(int x, int y);
        longint p;
        p = longint'(x) * longint'(y);
        return p >>> 16;
    endfunction

    function automatic int clip32(longint s);
        if (s > longint'(32'sh7FFFFFFF)) begin
            sat_now = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (s < -longint'(64'sd2147483648)) begin
            sat_now = 1'b1;
            return 32'sh80000000;
        end
        return int'(s);
    endfunction

    function automatic int clamp_dim(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Four-stage contraction: L, W1, W2, R
    task automatic contract_heff();
        int cl, cr, d, dm;
        longint s;
        cl = dim_l; cr = dim_r; d = dim_p; dm = dim_m;
        sat_now = 1'b0;
        for (int w = 0; w < dm; w++)
        for (int ap = 0; ap < cl; ap++)
        for (int s1 = 0; s1 < d; s1++)
        for (int s2 = 0; s2 < d; s2++)
        for (int b = 0; b < cr; b++) begin
            s = 0;
            for (int a = 0; a < cl; a++)
                s += mul_q16(env_left[a + w*cl + ap*cl*dm],
                             theta[a + s1*cl + s2*cl*d + b*cl*d*d]);
            scr_a[w + ap*dm + s1*dm*cl + s2*dm*cl*d + b*dm*cl*d*d] = clip32(s);
        end
        for (int wm = 0; wm < dm; wm++)
        for (int ap = 0; ap < cl; ap++)
        for (int s1p = 0; s1p < d; s1p++)
        for (int s2 = 0; s2 < d; s2++)
        for (int b = 0; b < cr; b++) begin
            s = 0;
            for (int w = 0; w < dm; w++)
                for (int s1 = 0; s1 < d; s1++)
                    s += mul_q16(op_left[w + s1*dm + s1p*dm*d + wm*dm*d*d],
                                 scr_a[w + ap*dm + s1*dm*cl + s2*dm*cl*d + b*dm*cl*d*d]);
            scr_b[wm + ap*dm + s1p*dm*cl + s2*dm*cl*d + b*dm*cl*d*d] = clip32(s);
        end
        for (int ap = 0; ap < cl; ap++)
        for (int s1p = 0; s1p < d; s1p++)
        for (int s2p = 0; s2p < d; s2p++)
        for (int wr = 0; wr < dm; wr++)
        for (int b = 0; b < cr; b++) begin
            s = 0;
            for (int wm = 0; wm < dm; wm++)
                for (int s2 = 0; s2 < d; s2++)
                    s += mul_q16(op_right[wm + s2*dm + s2p*dm*d + wr*dm*d*d],
                                 scr_b[wm + ap*dm + s1p*dm*cl + s2*dm*cl*d + b*dm*cl*d*d]);
            scr_a[ap + s1p*cl + s2p*cl*d + wr*cl*d*d + b*cl*d*d*dm] = clip32(s);
        end
        for (int ap = 0; ap < cl; ap++)
        for (int s1p = 0; s1p < d; s1p++)
        for (int s2p = 0; s2p < d; s2p++)
        for (int bp = 0; bp < cr; bp++) begin
            s = 0;
            for (int wr = 0; wr < dm; wr++)
                for (int b = 0; b < cr; b++)
                    s += mul_q16(env_right[b + wr*cr + bp*cr*dm],
                                 scr_a[ap + s1p*cl + s2p*cl*d + wr*cl*d*d + b*cl*d*d*dm]);
            heff_out[ap + s1p*cl + s2p*cl*d + bp*cl*d*d] = clip32(s);
            has_out[ap + s1p*cl + s2p*cl*d + bp*cl*d*d] = 1'b1;
        end
    endtask

    // Update the predictor for one accepted item
    task automatic predict_item(t_func f, int idx, int val);
        t_heff_result r;
        if (f != FN_NONE) items_done++;
        case (f)
            FN_LOAD_L:     begin env_left[idx] = val; has_left[idx] = 1'b1; end
            FN_LOAD_R:     begin env_right[idx] = val; has_right[idx] = 1'b1; end
            FN_LOAD_W1:    if (idx < OP_SIZE) begin op_left[idx] = val; has_w1[idx] = 1'b1; end
            FN_LOAD_W2:    if (idx < OP_SIZE) begin op_right[idx] = val; has_w2[idx] = 1'b1; end
            FN_LOAD_THETA: begin theta[idx] = val; has_theta[idx] = 1'b1; end
            FN_COMPUTE: begin
                contract_heff();
                r.kind = 1'b0; r.value = '0; r.sat = sat_now;
                sb.note_expected(r);
            end
            FN_READ: begin
                r.kind = 1'b1; r.value = heff_out[idx]; r.sat = sat_now;
                sb.note_expected(r);
            end
            default: ;
        endcase
    endtask

    // Present one item, wait for acceptance, then maybe leave a gap
    task automatic issue(t_func f, int idx, logic [31:0] val);
        logic [9:0] ix;
        ix = 10'(idx);
        i_start      <= 1'b1;
        i_func       <= f;
        i_elem_index <= ix;
        i_elem_value <= val;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_item(f, int'(ix), int'(val));
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Mix of small, full-range and extreme element values
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return $urandom_range(0, 32'h0007FFFF) - 32'h00040000;
        if (sel < 80) return $urandom;
        case ($urandom_range(4))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'hFFFFFFFF;
            3: return 32'h00010000;
            default: return 32'h0;
        endcase
    endfunction

    // Load any operand entry the current dimensions need, then compute
    task automatic issue_compute();
        for (int i = 0; i < dim_l*dim_m*dim_l; i++)
            if (!has_left[i]) issue(FN_LOAD_L, i, pick_value());
        for (int i = 0; i < dim_r*dim_m*dim_r; i++)
            if (!has_right[i]) issue(FN_LOAD_R, i, pick_value());
        for (int i = 0; i < dim_m*dim_p*dim_p*dim_m; i++) begin
            if (!has_w1[i]) issue(FN_LOAD_W1, i, pick_value());
            if (!has_w2[i]) issue(FN_LOAD_W2, i, pick_value());
        end
        for (int i = 0; i < dim_l*dim_p*dim_p*dim_r; i++)
            if (!has_theta[i]) issue(FN_LOAD_THETA, i, pick_value());
        issue(FN_COMPUTE, $urandom, $urandom);
    endtask

    // Register write, only once the block has drained
    task automatic write_cfg(logic [2:0] idx, logic [7:0] data);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 || o_busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_LEFT_BOND:  dim_l = clamp_dim(data & 8'h1F, 16);
            CFG_RIGHT_BOND: dim_r = clamp_dim(data & 8'h1F, 16);
            CFG_PHYS:       dim_p = clamp_dim(data & 8'h03, 2);
            CFG_MPO:        dim_m = clamp_dim(data & 8'h07, 4);
            default: ;
        endcase
    endtask

    task automatic write_all_cfg(logic [7:0] l, logic [7:0] r, logic [7:0] p, logic [7:0] m);
        write_cfg(CFG_LEFT_BOND, l);
        write_cfg(CFG_RIGHT_BOND, r);
        write_cfg(CFG_PHYS, p);
        write_cfg(CFG_MPO, m);
    endtask

    // One random group: loose loads, maybe noise, a compute, then reads
    task automatic random_group();
        t_func f;
        int idx, span;
        repeat ($urandom_range(1, 8)) begin
            f = t_func'($urandom_range(0, 4));
            if (f == FN_LOAD_W1 || f == FN_LOAD_W2)
                span = dim_m*dim_p*dim_p*dim_m;
            else if (f == FN_LOAD_THETA)
                span = dim_l*dim_p*dim_p*dim_r;
            else if (f == FN_LOAD_L)
                span = dim_l*dim_m*dim_l;
            else
                span = dim_r*dim_m*dim_r;
            idx = ($urandom_range(99) < 75) ? $urandom_range(span - 1) : $urandom_range(1023);
            issue(f, idx, pick_value());
        end
        if ($urandom_range(99) < 8) issue(FN_NONE, $urandom, $urandom);
        issue_compute();
        span = dim_l*dim_p*dim_p*dim_r;
        repeat ($urandom_range(1, 5)) issue(FN_READ, $urandom_range(span - 1), $urandom);
        // older results written under other dimensions
        idx = $urandom_range(1023);
        if (has_out[idx]) issue(FN_READ, idx, $urandom);
    endtask

    // Raw register settings, including zero and over-range values
    logic [7:0] set_l[8] = '{8'd16, 8'd1, 8'd2, 8'hFF, 8'd3, 8'd1, 8'd4, 8'd2};
    logic [7:0] set_r[8] = '{8'd1, 8'd16, 8'd2, 8'd1, 8'd3, 8'd0, 8'd2, 8'd3};
    logic [7:0] set_p[8] = '{8'd1, 8'd1, 8'd2, 8'd3, 8'd2, 8'd2, 8'd1, 8'd2};
    logic [7:0] set_m[8] = '{8'd1, 8'd1, 8'd4, 8'd1, 8'd2, 8'd7, 8'd3, 8'd2};
    int idle_plan[4] = '{0, 65, 0, 37};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all dimensions 1 (zero reads as one), extremes and saturation
        write_all_cfg(8'd0, 8'd0, 8'd0, 8'd0);
        issue(FN_LOAD_L, 10'd0, 32'h7FFFFFFF);
        issue(FN_LOAD_R, 10'd0, 32'h7FFFFFFF);
        issue(FN_LOAD_W1, 10'd0, 32'h7FFFFFFF);
        issue(FN_LOAD_W2, 10'd0, 32'h7FFFFFFF);
        issue(FN_LOAD_THETA, 10'd0, 32'h7FFFFFFF);
        issue(FN_LOAD_W1, 10'd1023, 32'h12345678);   // beyond operator depth, dropped
        issue(FN_LOAD_W2, 10'd64, 32'h87654321);
        issue(FN_NONE, 10'd0, 32'hFFFFFFFF);
        issue(FN_COMPUTE, 10'd0, 32'h0);
        issue(FN_READ, 10'd0, 32'h0);
        issue(FN_LOAD_L, 10'd0, 32'h80000000);
        issue(FN_LOAD_THETA, 10'd0, 32'h80000000);
        issue(FN_COMPUTE, 10'd1023, 32'hFFFFFFFF);
        issue(FN_READ, 10'd0, 32'h0);
        // floor rounding of a tiny negative product
        issue(FN_LOAD_L, 10'd0, 32'hFFFFFFFF);
        issue(FN_LOAD_THETA, 10'd0, 32'h00000001);
        issue(FN_LOAD_W1, 10'd0, 32'h00010000);
        issue(FN_LOAD_W2, 10'd0, 32'h00010000);
        issue(FN_LOAD_R, 10'd0, 32'h00010000);
        issue(FN_COMPUTE, 10'd0, 32'h0);
        issue(FN_READ, 10'd0, 32'h0);
        issue(FN_LOAD_L, 10'd1023, 32'h55555555);
        issue(FN_LOAD_THETA, 10'd1023, 32'hAAAAAAAA);

        // Random phases over several register settings and idle rates
        for (int ph = 0; ph < 8; ph++) begin
            write_all_cfg(set_l[ph], set_r[ph], set_p[ph], set_m[ph]);
            idle_pct = idle_plan[ph % 4];
            items_done = 0;
            while (items_done < PHASE_ITEMS) random_group();
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/tshc_pkg.sv
design/tshc_ctrl.sv
design/tshc_datapath.sv
design/two_site_heff_contraction.sv
bench/two_site_heff_contraction_tb.sv
